@@ rtl/ocs_pkg.sv @@
// Shared types, constants and the microcode table of the output VC candidate set.
`default_nettype none

package ocs_pkg;

    // Sizing of the candidate set
    localparam int NUM_PORTS       = 8;
    localparam int RANGES_PER_PORT = 4;
    localparam int NUM_VCS         = 16;
    localparam int SLOTS           = NUM_PORTS * RANGES_PER_PORT;
    localparam int ADDR_W          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int USED_W          = $clog2(RANGES_PER_PORT + 1);

    // Field widths of the request and result words
    localparam int REQ_W  = 3;
    localparam int PORT_W = 3;
    localparam int VC_W   = 4;
    localparam int PRI_W  = 16;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;
    localparam int LEN_W  = VC_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EMPTY  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INDEX  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SINGLE = 3'd5;

    // Microprogram addresses
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_CLEAR    = 4'd0;
    localparam step_t ST_ADD      = 4'd1;
    localparam step_t ST_EMPTY    = 4'd2;
    localparam step_t ST_CNT_RD   = 4'd3;
    localparam step_t ST_CNT_ACC  = 4'd4;
    localparam step_t ST_SGL_RD   = 4'd5;
    localparam step_t ST_SGL_CHK  = 4'd6;
    localparam step_t ST_IDX_RD   = 4'd7;
    localparam step_t ST_IDX_LOOK = 4'd8;
    localparam step_t ST_DONE     = 4'd9;
    localparam step_t ST_FETCH    = 4'd10;

    // Datapath operation of one control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_CLEAR,
        OP_ADD,
        OP_EMPTY,
        OP_RD_SLOT,
        OP_CNT_ACC,
        OP_SGL_RD,
        OP_SGL_CHK,
        OP_IDX_LOOK,
        OP_EMIT
    } op_t;

    // Jump condition of one control word
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_NO_MORE,
        C_MISS,
        C_NOT_SOLE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic no_more;
        logic miss;
        logic not_sole;
    } dp_flags_t;

    // One stored VC range
    typedef struct packed {
        logic signed [PRI_W-1:0] priority_v;
        logic [VC_W-1:0]         vc_last;
        logic [VC_W-1:0]         vc_first;
    } range_t;

    // Request operands, lowest field last
    typedef struct packed {
        logic [POS_W-1:0]        vc_position;
        logic signed [PRI_W-1:0] priority_in;
        logic [VC_W-1:0]         vc_last;
        logic [VC_W-1:0]         vc_first;
        logic [PORT_W-1:0]       port;
    } req_t;

    // Result word, lowest field last
    typedef struct packed {
        logic                    overflow;
        logic                    is_empty;
        logic [CNT_W-1:0]        vc_count;
        logic [PORT_W-1:0]       port_out;
        logic signed [PRI_W-1:0] priority_out;
        logic [VC_W-1:0]         vc_out;
        logic                    found;
    } out_word_t;

    localparam int IN_TDATA_W  = (($bits(req_t) + 7) / 8) * 8;
    localparam int OUT_TDATA_W = (($bits(out_word_t) + 7) / 8) * 8;

    // Flat slot address of a port's range
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [PORT_W-1:0] port,
                                                    input logic [USED_W-1:0] slot);
        slot_addr = ADDR_W'(int'(port) * RANGES_PER_PORT + int'(slot));
    endfunction

    // Entry step of each request
    function automatic step_t dispatch(input logic [REQ_W-1:0] req);
        step_t s;
        unique case (req)
            REQ_CLEAR:  s = ST_CLEAR;
            REQ_ADD:    s = ST_ADD;
            REQ_EMPTY:  s = ST_EMPTY;
            REQ_COUNT:  s = ST_CNT_RD;
            REQ_INDEX:  s = ST_IDX_RD;
            REQ_SINGLE: s = ST_SGL_RD;
            default:    s = ST_DONE;
        endcase
        return s;
    endfunction

    // Control store: one word per step
    function automatic ctl_t ucode(input step_t s);
        ctl_t w;
        unique case (s)
            ST_CLEAR:    w = '{op: OP_CLEAR,    cond: C_ALWAYS,   target: ST_DONE};
            ST_ADD:      w = '{op: OP_ADD,      cond: C_ALWAYS,   target: ST_DONE};
            ST_EMPTY:    w = '{op: OP_EMPTY,    cond: C_ALWAYS,   target: ST_DONE};
            ST_CNT_RD:   w = '{op: OP_RD_SLOT,  cond: C_NO_MORE,  target: ST_DONE};
            ST_CNT_ACC:  w = '{op: OP_CNT_ACC,  cond: C_ALWAYS,   target: ST_CNT_RD};
            ST_SGL_RD:   w = '{op: OP_SGL_RD,   cond: C_NOT_SOLE, target: ST_DONE};
            ST_SGL_CHK:  w = '{op: OP_SGL_CHK,  cond: C_ALWAYS,   target: ST_DONE};
            ST_IDX_RD:   w = '{op: OP_RD_SLOT,  cond: C_NO_MORE,  target: ST_DONE};
            ST_IDX_LOOK: w = '{op: OP_IDX_LOOK, cond: C_MISS,     target: ST_IDX_RD};
            ST_DONE:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: ST_DONE};
            ST_FETCH:    w = '{op: OP_FETCH,    cond: C_DISPATCH, target: ST_FETCH};
            default:     w = '{op: OP_NOP,      cond: C_ALWAYS,   target: ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ocs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ocs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/ocs_seq.sv @@
// Microprogram sequencer: step counter, control store and jump logic.
`default_nettype none

module ocs_seq (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [ocs_pkg::REQ_W-1:0] req_type,
    input  ocs_pkg::dp_flags_t       flags,
    input  logic                     out_busy,
    output ocs_pkg::ctl_t            ctl
);
    import ocs_pkg::*;

    step_t upc_reg;
    step_t upc_next;

    // Look up the current control word
    assign ctl = ucode(upc_reg);

    // Pick the next step
    always_comb begin
        upc_next = upc_reg + step_t'(1);
        unique case (ctl.cond)
            C_ALWAYS:   upc_next = ctl.target;
            C_DISPATCH: upc_next = accept ? dispatch(req_type) : upc_reg;
            C_NO_MORE:  if (flags.no_more) upc_next = ctl.target;
            C_MISS:     if (flags.miss) upc_next = ctl.target;
            C_NOT_SOLE: if (flags.not_sole) upc_next = ctl.target;
            C_OUT_BUSY: if (out_busy) upc_next = ctl.target;
            default:    upc_next = ST_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    ap_leave_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ctl.op != OP_FETCH)
        else $error("sequencer stayed in fetch after taking a word");

    ap_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg <= ST_FETCH)
        else $error("step counter outside the program");

endmodule

`default_nettype wire

@@ rtl/ocs_dpath.sv @@
// Datapath: range store, per-port range counts, walk registers and result word.
`default_nettype none

module ocs_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ocs_pkg::ctl_t         ctl,
    input  logic                  accept,
    input  ocs_pkg::req_t         req,
    output ocs_pkg::dp_flags_t    flags,
    output ocs_pkg::out_word_t    result
);
    import ocs_pkg::*;

    req_t              req_reg;
    logic [USED_W-1:0] k_reg, k_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    out_word_t         res_reg, res_next;
    logic [USED_W-1:0] used_reg [NUM_PORTS];
    logic [USED_W-1:0] used_next [NUM_PORTS];

    logic              port_ok;
    logic [USED_W-1:0] used_cur;
    logic              add_ok;
    logic              add_full;
    logic [NUM_PORTS-1:0] used_nz;
    logic [PORT_W-1:0] sole_port;
    range_t            rd_data;
    range_t            wr_data;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [LEN_W-1:0]  len;
    logic              hit;

    // Decode the latched request
    assign port_ok  = int'(req_reg.port) < NUM_PORTS;
    assign used_cur = port_ok ? used_reg[req_reg.port] : '0;
    assign add_ok   = port_ok && (req_reg.vc_first <= req_reg.vc_last)
                      && (int'(req_reg.vc_last) < NUM_VCS);
    assign add_full = used_cur >= USED_W'(RANGES_PER_PORT);

    // Find used ports and the last one of them
    always_comb begin
        sole_port = '0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            used_nz[p] = used_reg[p] != '0;
            if (used_nz[p]) begin
                sole_port = PORT_W'(p);
            end
        end
    end

    // Range store access
    assign ram_we    = (ctl.op == OP_ADD) && add_ok && !add_full;
    assign ram_waddr = slot_addr(req_reg.port, used_cur);
    assign wr_data   = '{priority_v: req_reg.priority_in, vc_last: req_reg.vc_last,
                         vc_first: req_reg.vc_first};
    assign ram_raddr = (ctl.op == OP_SGL_RD) ? slot_addr(sole_port, '0)
                                             : slot_addr(req_reg.port, k_reg);

    ocs_ram #(
        .WIDTH ($bits(range_t)),
        .DEPTH (SLOTS)
    ) u_range_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_data),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Length of the range just read, and index hit test
    assign len = LEN_W'(rd_data.vc_last) - LEN_W'(rd_data.vc_first) + LEN_W'(1);
    assign hit = rem_reg < POS_W'(len);

    assign flags.no_more  = k_reg >= used_cur;
    assign flags.miss     = !hit;
    assign flags.not_sole = $countones(used_nz) != 1;

    assign result = res_reg;

    // Execute the control word
    always_comb begin
        logic [CNT_W:0] sum;
        sum       = {1'b0, res_reg.vc_count} + (CNT_W + 1)'(len);
        k_next    = k_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        used_next = used_reg;
        unique case (ctl.op)
            OP_FETCH: begin
                if (accept) begin
                    k_next   = '0;
                    rem_next = req.vc_position;
                    res_next = '{overflow: 1'b0, is_empty: 1'b0, vc_count: '0,
                                 port_out: '0, priority_out: '1, vc_out: '0,
                                 found: 1'b0};
                end
            end
            OP_CLEAR: begin
                for (int p = 0; p < NUM_PORTS; p++) begin
                    used_next[p] = '0;
                end
            end
            OP_ADD: begin
                if (add_ok) begin
                    if (add_full) begin
                        res_next.overflow = 1'b1;
                    end else begin
                        used_next[req_reg.port] = used_cur + USED_W'(1);
                    end
                end
            end
            OP_EMPTY: begin
                res_next.is_empty = !port_ok || (used_cur == '0);
            end
            OP_CNT_ACC: begin
                res_next.vc_count = (sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_MAX
                                                                  : sum[CNT_W-1:0];
                k_next = k_reg + USED_W'(1);
            end
            OP_IDX_LOOK: begin
                if (hit) begin
                    res_next.found        = 1'b1;
                    res_next.vc_out       = rd_data.vc_first + VC_W'(rem_reg);
                    res_next.priority_out = rd_data.priority_v;
                end else begin
                    rem_next = rem_reg - POS_W'(len);
                    k_next   = k_reg + USED_W'(1);
                end
            end
            OP_SGL_CHK: begin
                if (rd_data.vc_first == rd_data.vc_last) begin
                    res_next.found    = 1'b1;
                    res_next.vc_out   = rd_data.vc_first;
                    res_next.port_out = sole_port;
                end
            end
            default: ;
        endcase
    end

    // Range counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                used_reg[p] <= '0;
            end
        end else begin
            used_reg <= used_next;
        end
    end

    // Operands and working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req;
        end
        k_reg   <= k_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    ap_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == OP_CLEAR) |=> (used_nz == '0))
        else $error("range counts not cleared");

    ap_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op != OP_FETCH) |-> (used_cur <= USED_W'(RANGES_PER_PORT)))
        else $error("range count above list size");

    ap_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == OP_ADD && add_ok && add_full) |=> (used_cur == $past(used_cur)))
        else $error("dropped add changed the range count");

endmodule

`default_nettype wire

@@ rtl/output_vc_candidate_set.sv @@
// Top level of the output VC candidate set: stream ports, result register, sequencer.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser: req_type; tdata: request operands
//  m_axis    out  m_axis_tvalid/tready      tdata: result word
//
//  Clear, add and empty test pass from fetch through their execute step to the
//  final step; unused codes go straight to the final step. A single port VC query
//  reads the first range of the sole used port and checks it, unless the number
//  of used ports is not one. A count or index query alternates a read step and an
//  accumulate or lookup step per range walked; the range store's read is registered.
//  Reset clears the step counter, range counts and result valid at once.
//  A new word is taken as soon as the sequencer is back in fetch, even while the
//  last result waits; a stalled result holds the sequencer in its final step.
`default_nettype none

module output_vc_candidate_set (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // port, vc_first, vc_last, priority_in, vc_position (lowest first)
    input  logic [ocs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [ocs_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found, vc_out, priority_out, port_out, vc_count, is_empty, overflow (lowest first)
    output logic [ocs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ocs_pkg::*;

    ctl_t      ctl;
    dp_flags_t dp_flags;
    out_word_t result;
    req_t      req;
    logic      accept;
    logic      out_free;
    logic      emit;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg;

    // Input handshake
    assign s_axis_tready = (ctl.op == OP_FETCH);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = req_t'(s_axis_tdata[$bits(req_t)-1:0]);

    // Output register handshake
    assign out_free = !m_valid_reg || m_axis_tready;
    assign emit     = (ctl.op == OP_EMIT) && out_free;

    ocs_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .req_type (s_axis_tuser),
        .flags    (dp_flags),
        .out_busy (!out_free),
        .ctl      (ctl)
    );

    ocs_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .accept  (accept),
        .req     (req),
        .flags   (dp_flags),
        .result  (result)
    );

    // Load a finished result, drop valid once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire
